// File: rtl/tnva_pkg.sv
// ----------------------------------------------------------------------------
// tnva_pkg
// Shared types and constants for the timed note voice allocator.
// ----------------------------------------------------------------------------
package tnva_pkg;

    // Default number of voice slots
    localparam int VOICES_DEF = 8;

    // Most note-offs a single tick may release
    localparam int MAX_RESULTS = 8;
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    // Ramp time requested on release
    localparam logic [31:0] RELEASE_RAMP_MS = 32'd225;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICES_IN_USE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_NOTE_CHANNEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_CHANNEL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MODE           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MAX_BRIGHTNESS = 3'd4;
    localparam int CFG_DATA_W = 8;

    // LED modes (code three means no LED as well)
    localparam logic [1:0] LED_NONE      = 2'd0;
    localparam logic [1:0] LED_SLOT      = 2'd1;
    localparam logic [1:0] LED_SLOT_PLUS = 2'd2;

    typedef enum logic {
        OP_NOTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        EV_ON  = 1'b0,
        EV_OFF = 1'b1
    } t_kind;

    // Configuration seen by the back part
    typedef struct packed {
        logic [3:0] voices_in_use;
        logic       use_note_channel;
        logic [4:0] global_channel;
        logic [1:0] led_mode;
        logic [7:0] led_max_brightness;
    } t_cfg;

    // Classified command word
    typedef struct packed {
        t_op         op;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [4:0]  channel;
        logic [31:0] hold_ms;
        logic [31:0] expiry;
        logic [31:0] now_ms;
    } t_cmd;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // One result word
    typedef struct packed {
        t_kind       event_kind;
        logic [6:0]  out_note;
        logic [6:0]  out_velocity;
        logic [4:0]  out_channel;
        logic [2:0]  slot_index;
        logic        led_enable;
        logic [3:0]  led_index;
        logic [7:0]  led_level;
        logic [31:0] led_ramp_ms;
        logic        last;
    } t_res;

endpackage

// File: rtl/timed_note_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// timed_note_voice_allocator_unit
// Polyphonic voice allocator with timed release and LED ramp requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. The back part examines one voice
// slot per cycle: an item leaves the queue, then the walk examines slots,
// and a closing step ends the walk when no slot is taken: a note request
// stops at the first free slot, a tick walks all active slots (min of
// voices_in_use and VOICES) or stops after its eighth release. Results
// appear for exactly one cycle on o_strobe and cannot be held off; o_last
// marks the final result of an item.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module timed_note_voice_allocator_unit #(
    parameter int VOICES = tnva_pkg::VOICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [6:0]                          i_note_number,
    input  logic [6:0]                          i_note_velocity,
    input  logic [31:0]                         i_hold_ms,
    input  logic [4:0]                          i_note_channel,
    input  logic [31:0]                         i_now_ms,
    // results
    output logic                                o_strobe,
    output logic                                o_event_kind,
    output logic [6:0]                          o_out_note,
    output logic [6:0]                          o_out_velocity,
    output logic [4:0]                          o_out_channel,
    output logic [2:0]                          o_slot_index,
    output logic                                o_led_enable,
    output logic [3:0]                          o_led_index,
    output logic [7:0]                          o_led_level,
    output logic [31:0]                         o_led_ramp_ms,
    output logic                                o_last,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tnva_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tnva_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    tnva_pkg::t_cfg    r_cfg;
    tnva_pkg::t_cmd    push_cmd;
    tnva_pkg::t_cmd    head_cmd;
    tnva_pkg::t_qstat  q_stat;
    tnva_pkg::t_res    res;
    logic              push;
    logic              pop;
    logic              strobe;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voices_in_use      <= 4'd8;
            r_cfg.use_note_channel   <= 1'b0;
            r_cfg.global_channel     <= 5'd1;
            r_cfg.led_mode           <= tnva_pkg::LED_NONE;
            r_cfg.led_max_brightness <= 8'd255;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tnva_pkg::CFG_VOICES_IN_USE:      r_cfg.voices_in_use      <= i_cfg_data[3:0];
                tnva_pkg::CFG_USE_NOTE_CHANNEL:   r_cfg.use_note_channel   <= i_cfg_data[0];
                tnva_pkg::CFG_GLOBAL_CHANNEL:     r_cfg.global_channel     <= i_cfg_data[4:0];
                tnva_pkg::CFG_LED_MODE:           r_cfg.led_mode           <= i_cfg_data[1:0];
                tnva_pkg::CFG_LED_MAX_BRIGHTNESS: r_cfg.led_max_brightness <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: accept and classify
    tnva_front u_front (
        .i_start         (start),
        .i_full          (q_stat.full),
        .i_operation     (i_operation),
        .i_note_number   (i_note_number),
        .i_note_velocity (i_note_velocity),
        .i_hold_ms       (i_hold_ms),
        .i_note_channel  (i_note_channel),
        .i_now_ms        (i_now_ms),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    // Command queue
    tnva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // Back: slot table and sequencer
    tnva_back #(
        .VOICES (VOICES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head_cmd),
        .i_empty  (q_stat.empty),
        .o_pop    (pop),
        .o_strobe (strobe),
        .o_res    (res)
    );

    // Drive result ports
    assign busy           = q_stat.full;
    assign o_strobe       = strobe;
    assign o_event_kind   = res.event_kind;
    assign o_out_note     = res.out_note;
    assign o_out_velocity = res.out_velocity;
    assign o_out_channel  = res.out_channel;
    assign o_slot_index   = res.slot_index;
    assign o_led_enable   = res.led_enable;
    assign o_led_index    = res.led_index;
    assign o_led_level    = res.led_level;
    assign o_led_ramp_ms  = res.led_ramp_ms;
    assign o_last         = res.last;

    // Back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // A pushed word leaves the queue non-empty unless popped at once
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> !q_stat.empty)
        else $error("pushed command lost");

    // Note-off carries zero velocity and zero LED level
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_event_kind == tnva_pkg::EV_OFF)) |->
            (o_out_velocity == 7'd0) && (o_led_level == 8'd0))
        else $error("note-off with nonzero velocity or level");

    // LED fields stay clear when no LED ramp is requested
    a_led_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_led_enable) |->
            (o_led_index == 4'd0) && (o_led_level == 8'd0) && (o_led_ramp_ms == 32'd0))
        else $error("LED fields set while LED disabled");

endmodule

// File: rtl/tnva_front.sv
// ----------------------------------------------------------------------------
// tnva_front
// Accepts request words, classifies them and precomputes the note expiry.
// ----------------------------------------------------------------------------
module tnva_front (
    input  logic              i_start,
    input  logic              i_full,
    input  logic              i_operation,
    input  logic [6:0]        i_note_number,
    input  logic [6:0]        i_note_velocity,
    input  logic [31:0]       i_hold_ms,
    input  logic [4:0]        i_note_channel,
    input  logic [31:0]       i_now_ms,
    output logic              o_push,
    output tnva_pkg::t_cmd    o_cmd
);

    // Take a word whenever the queue has room
    assign o_push = i_start & ~i_full;

    // Build the command word; expiry wraps at 32 bits
    always_comb begin
        o_cmd.op       = tnva_pkg::t_op'(i_operation);
        o_cmd.note     = i_note_number;
        o_cmd.velocity = i_note_velocity;
        o_cmd.channel  = i_note_channel;
        o_cmd.hold_ms  = i_hold_ms;
        o_cmd.expiry   = i_now_ms + i_hold_ms;
        o_cmd.now_ms   = i_now_ms;
    end

endmodule

// File: rtl/tnva_queue.sv
// ----------------------------------------------------------------------------
// tnva_queue
// Short command queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module tnva_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tnva_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output tnva_pkg::t_cmd    o_head,
    output tnva_pkg::t_qstat  o_stat
);

    tnva_pkg::t_cmd                    r_mem [tnva_pkg::QDEPTH];
    logic [tnva_pkg::QPTR_W-1:0]       r_wp;
    logic [tnva_pkg::QPTR_W-1:0]       r_rp;
    logic [tnva_pkg::QCNT_W-1:0]       r_cnt;

    // Status
    assign o_stat.full  = (r_cnt == tnva_pkg::QCNT_W'(tnva_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/tnva_back.sv
// ----------------------------------------------------------------------------
// tnva_back
// Voice slot table and sequencer: one slot examined per cycle, results
// registered. Note-offs are held one step so the last one can be marked.
// ----------------------------------------------------------------------------
module tnva_back #(
    parameter int VOICES = tnva_pkg::VOICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tnva_pkg::t_cfg    i_cfg,
    input  tnva_pkg::t_cmd    i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_strobe,
    output tnva_pkg::t_res    o_res
);

    localparam int SLOT_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W  = $clog2(VOICES + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        tnva_pkg::t_kind    kind;
        logic [SLOT_W-1:0]  slot;
        logic [6:0]         note;
        logic [6:0]         velocity;
        logic [4:0]         channel;
    } t_evt;

    t_state                       r_state;
    tnva_pkg::t_cmd               r_cmd;
    logic [CNT_W-1:0]             r_idx;
    logic [tnva_pkg::RCNT_W-1:0]  r_cnt;
    logic                         r_pend_v;
    t_evt                         r_pend;
    logic                         r_strobe;
    tnva_pkg::t_res               r_res;

    logic [6:0]                   r_vel  [VOICES];
    logic [6:0]                   r_note [VOICES];
    logic [31:0]                  r_exp  [VOICES];
    logic [4:0]                   r_chan [VOICES];

    logic [SLOT_W-1:0]            slot;
    logic [CNT_W-1:0]             n_active;
    logic                         scan_end;
    logic                         take;
    logic                         release_hit;
    t_evt                         ev_on;
    t_evt                         ev_off;

    // Format an event into a result word
    function automatic tnva_pkg::t_res fmt(t_evt e, logic last, tnva_pkg::t_cfg c,
                                           logic [31:0] hold);
        tnva_pkg::t_res r;
        logic           en;
        logic [31:0]    s;
        logic [31:0]    sp;
        en = (c.led_mode == tnva_pkg::LED_SLOT) || (c.led_mode == tnva_pkg::LED_SLOT_PLUS);
        s  = 32'(e.slot);
        sp = s + 32'd1;
        r.event_kind   = e.kind;
        r.out_note     = e.note;
        r.out_velocity = e.velocity;
        r.out_channel  = c.use_note_channel ? e.channel : c.global_channel;
        r.slot_index   = s[2:0];
        r.led_enable   = en;
        r.led_index    = !en ? 4'd0 :
                         (c.led_mode == tnva_pkg::LED_SLOT_PLUS) ? sp[3:0] : s[3:0];
        r.led_level    = !en ? 8'd0 :
                         (e.kind == tnva_pkg::EV_ON) ? c.led_max_brightness : 8'd0;
        r.led_ramp_ms  = !en ? 32'd0 :
                         (e.kind == tnva_pkg::EV_ON) ? hold : tnva_pkg::RELEASE_RAMP_MS;
        r.last         = last;
        return r;
    endfunction

    // Decode the current slot
    always_comb begin
        slot     = r_idx[SLOT_W-1:0];
        n_active = (32'(i_cfg.voices_in_use) > 32'(VOICES)) ? CNT_W'(VOICES)
                                                              : CNT_W'(i_cfg.voices_in_use);
        scan_end = (r_idx >= n_active) ||
                   ((r_cmd.op == tnva_pkg::OP_TICK) &&
                    (r_cnt == tnva_pkg::RCNT_W'(tnva_pkg::MAX_RESULTS)));
        take        = (r_state == S_SCAN) && !scan_end &&
                      (r_cmd.op == tnva_pkg::OP_NOTE) && (r_vel[slot] == 7'd0);
        release_hit = (r_state == S_SCAN) && !scan_end &&
                      (r_cmd.op == tnva_pkg::OP_TICK) && (r_vel[slot] != 7'd0) &&
                      (r_exp[slot] <= r_cmd.now_ms);

        ev_on.kind     = tnva_pkg::EV_ON;
        ev_on.slot     = slot;
        ev_on.note     = r_cmd.note;
        ev_on.velocity = r_cmd.velocity;
        ev_on.channel  = r_cmd.channel;

        ev_off.kind     = tnva_pkg::EV_OFF;
        ev_off.slot     = slot;
        ev_off.note     = r_note[slot];
        ev_off.velocity = 7'd0;
        ev_off.channel  = r_chan[slot];
    end

    // Pop the next command when idle
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Store note data of a taken slot
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_note[slot] <= r_cmd.note;
            r_exp[slot]  <= r_cmd.expiry;
            r_chan[slot] <= r_cmd.channel;
        end
    end

    // Sequencer, slot velocities and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pend_v <= 1'b0;
            r_idx    <= '0;
            r_cnt    <= '0;
            for (int i = 0; i < VOICES; i++) begin
                r_vel[i] <= 7'd0;
            end
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd    <= i_head;
                        r_idx    <= '0;
                        r_cnt    <= '0;
                        r_pend_v <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_end) begin
                        // flush the held note-off as the last one
                        if (r_pend_v) begin
                            r_res    <= fmt(r_pend, 1'b1, i_cfg, r_cmd.hold_ms);
                            r_strobe <= 1'b1;
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end else if (take) begin
                        r_vel[slot] <= r_cmd.velocity;
                        r_res       <= fmt(ev_on, 1'b1, i_cfg, r_cmd.hold_ms);
                        r_strobe    <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        if (release_hit) begin
                            r_vel[slot] <= 7'd0;
                            if (r_pend_v) begin
                                r_res    <= fmt(r_pend, 1'b0, i_cfg, r_cmd.hold_ms);
                                r_strobe <= 1'b1;
                            end
                            r_pend   <= ev_off;
                            r_pend_v <= 1'b1;
                            r_cnt    <= r_cnt + 1'b1;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sim/timed_note_voice_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// timed_note_voice_allocator_unit_tb
// Self-checking bench for the voice allocator: a queue-fed driver presents
// note requests and ticks, a clocked monitor predicts the note-on and note-off
// words from its own copy of the voice table and compares every result word
// field by field, over several register settings and idle patterns.
// ----------------------------------------------------------------------------
module timed_note_voice_allocator_unit_tb;

    localparam int VOICE_SLOTS  = tnva_pkg::VOICES_DEF;
    localparam int DRAIN_CYCLES = 32;
    localparam int STALL_LIMIT  = 2000;

    // Spare LED mode code, behaves as no LED
    localparam logic [1:0] LED_MODE_SPARE = 2'd3;

    typedef struct packed {
        tnva_pkg::t_op op;
        logic [6:0]    note;
        logic [6:0]    velocity;
        logic [31:0]   hold_ms;
        logic [4:0]    channel;
        logic [31:0]   now_ms;
        logic          drain_first;
    } t_voice_req;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic                           i_operation;
    logic [6:0]                     i_note_number;
    logic [6:0]                     i_note_velocity;
    logic [31:0]                    i_hold_ms;
    logic [4:0]                     i_note_channel;
    logic [31:0]                    i_now_ms;
    logic                           o_strobe;
    logic                           o_event_kind;
    logic [6:0]                     o_out_note;
    logic [6:0]                     o_out_velocity;
    logic [4:0]                     o_out_channel;
    logic [2:0]                     o_slot_index;
    logic                           o_led_enable;
    logic [3:0]                     o_led_index;
    logic [7:0]                     o_led_level;
    logic [31:0]                    o_led_ramp_ms;
    logic                           o_last;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [tnva_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tnva_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Predicted voice table and registers
    tnva_pkg::t_cfg shadow_cfg;
    logic [6:0]     voice_vel    [VOICE_SLOTS];
    logic [6:0]     voice_note   [VOICE_SLOTS];
    logic [31:0]    voice_expiry [VOICE_SLOTS];
    logic [4:0]     voice_chan   [VOICE_SLOTS];

    t_voice_req      req_q[$];
    tnva_pkg::t_res  event_q[$];
    t_voice_req      cur_req;
    logic            req_taken;
    int              send_idle_pct;
    int              mismatch_cnt;
    int              stall_cycles;
    logic [31:0]     wall_ms;

    timed_note_voice_allocator_unit #(
        .VOICES(VOICE_SLOTS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operation(i_operation),
        .i_note_number(i_note_number),
        .i_note_velocity(i_note_velocity),
        .i_hold_ms(i_hold_ms),
        .i_note_channel(i_note_channel),
        .i_now_ms(i_now_ms),
        .o_strobe(o_strobe),
        .o_event_kind(o_event_kind),
        .o_out_note(o_out_note),
        .o_out_velocity(o_out_velocity),
        .o_out_channel(o_out_channel),
        .o_slot_index(o_slot_index),
        .o_led_enable(o_led_enable),
        .o_led_index(o_led_index),
        .o_led_level(o_led_level),
        .o_led_ramp_ms(o_led_ramp_ms),
        .o_last(o_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // Free-running clock, period 8
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Build one event word under the current LED and channel settings
    function automatic tnva_pkg::t_res make_event(input tnva_pkg::t_kind kind,
                                                  input int slot,
                                                  input logic [6:0] note,
                                                  input logic [6:0] vel,
                                                  input logic [4:0] chan,
                                                  input logic [7:0] level,
                                                  input logic [31:0] ramp);
        tnva_pkg::t_res ev;
        logic led_on;
        led_on = (shadow_cfg.led_mode == tnva_pkg::LED_SLOT) ||
                 (shadow_cfg.led_mode == tnva_pkg::LED_SLOT_PLUS);
        ev.event_kind   = kind;
        ev.out_note     = note;
        ev.out_velocity = vel;
        ev.out_channel  = shadow_cfg.use_note_channel ? chan
                                                      : shadow_cfg.global_channel;
        ev.slot_index   = slot[2:0];
        ev.led_enable   = led_on;
        ev.led_index    = !led_on ? 4'd0 :
                          (shadow_cfg.led_mode == tnva_pkg::LED_SLOT_PLUS) ? 4'(slot + 1)
                                                                           : 4'(slot);
        ev.led_level    = led_on ? level : 8'd0;
        ev.led_ramp_ms  = led_on ? ramp : 32'd0;
        ev.last         = 1'b0;
        return ev;
    endfunction

    // Allocate or release voices for one accepted word and queue its events
    task automatic predict_voices(input t_voice_req rq);
        int  slots;
        int  released;
        logic done;
        slots    = (shadow_cfg.voices_in_use > VOICE_SLOTS) ? VOICE_SLOTS
                                                            : shadow_cfg.voices_in_use;
        released = 0;
        done     = 1'b0;
        if (rq.op == tnva_pkg::OP_NOTE) begin
            for (int s = 0; s < slots; s++) begin
                if (!done && voice_vel[s] == 7'd0) begin
                    voice_note[s]   = rq.note;
                    voice_vel[s]    = rq.velocity;
                    voice_expiry[s] = rq.now_ms + rq.hold_ms;
                    voice_chan[s]   = rq.channel;
                    event_q.push_back(make_event(tnva_pkg::EV_ON, s, rq.note,
                                                 rq.velocity, rq.channel,
                                                 shadow_cfg.led_max_brightness,
                                                 rq.hold_ms));
                    released = 1;
                    done     = 1'b1;
                end
            end
        end else begin
            for (int s = 0; s < slots; s++) begin
                if (released < tnva_pkg::MAX_RESULTS && voice_vel[s] != 7'd0 &&
                    voice_expiry[s] <= rq.now_ms) begin
                    event_q.push_back(make_event(tnva_pkg::EV_OFF, s, voice_note[s],
                                                 7'd0, voice_chan[s], 8'd0,
                                                 tnva_pkg::RELEASE_RAMP_MS));
                    voice_vel[s] = 7'd0;
                    released++;
                end
            end
        end
        if (released > 0)
            event_q[event_q.size() - 1].last = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // Drive the next request word at the falling edge
    always @(negedge i_clk) begin
        if (!start || req_taken) begin
            req_taken = 1'b0;
            if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                !(req_q[0].drain_first && event_q.size() != 0)) begin
                cur_req = req_q.pop_front();
                i_operation     <= cur_req.op;
                i_note_number   <= cur_req.note;
                i_note_velocity <= cur_req.velocity;
                i_hold_ms       <= cur_req.hold_ms;
                i_note_channel  <= cur_req.channel;
                i_now_ms        <= cur_req.now_ms;
                start           <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Take accepted words, check result words, watch for a hang
    always @(posedge i_clk) begin
        tnva_pkg::t_res want;
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_voices(cur_req);
                req_taken = 1'b1;
            end
            if (o_strobe) begin
                if (event_q.size() == 0) begin
                    $error("result word with no event pending");
                    mismatch_cnt++;
                end else begin
                    want = event_q.pop_front();
                    compare_field("event_kind",   want.event_kind,   o_event_kind);
                    compare_field("out_note",     want.out_note,     o_out_note);
                    compare_field("out_velocity", want.out_velocity, o_out_velocity);
                    compare_field("out_channel",  want.out_channel,  o_out_channel);
                    compare_field("slot_index",   want.slot_index,   o_slot_index);
                    compare_field("led_enable",   want.led_enable,   o_led_enable);
                    compare_field("led_index",    want.led_index,    o_led_index);
                    compare_field("led_level",    want.led_level,    o_led_level);
                    compare_field("led_ramp_ms",  want.led_ramp_ms,  o_led_ramp_ms);
                    compare_field("last",         want.last,         o_last);
                end
            end
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timed_note_voice_allocator_unit_tb: errors");
                $finish;
            end
        end
    end

    task automatic push_req(input tnva_pkg::t_op op, input logic [6:0] note,
                            input logic [6:0] vel, input logic [31:0] hold,
                            input logic [4:0] chan, input logic [31:0] now,
                            input logic drain);
        t_voice_req rq;
        rq.op          = op;
        rq.note        = note;
        rq.velocity    = vel;
        rq.hold_ms     = hold;
        rq.channel     = chan;
        rq.now_ms      = now;
        rq.drain_first = drain;
        req_q.push_back(rq);
    endtask

    // Hold until every word is taken, every event seen and the block settled
    task automatic wait_quiet();
        while (req_q.size() != 0 || start || event_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tnva_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tnva_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tnva_pkg::CFG_VOICES_IN_USE:
                shadow_cfg.voices_in_use      = val[3:0];
            tnva_pkg::CFG_USE_NOTE_CHANNEL:
                shadow_cfg.use_note_channel   = val[0];
            tnva_pkg::CFG_GLOBAL_CHANNEL:
                shadow_cfg.global_channel     = val[4:0];
            tnva_pkg::CFG_LED_MODE:
                shadow_cfg.led_mode           = val[1:0];
            tnva_pkg::CFG_LED_MAX_BRIGHTNESS:
                shadow_cfg.led_max_brightness = val;
            default: ;
        endcase
    endtask

    // Mostly a steady wall clock with short holds, so ticks release voices
    task automatic queue_random(input int count);
        int          pick;
        int          hpick;
        logic [6:0]  vel;
        logic [4:0]  chan;
        logic [31:0] hold;
        logic [31:0] now;
        for (int k = 0; k < count; k++) begin
            wall_ms = wall_ms + $urandom_range(0, 40);
            pick    = $urandom_range(0, 99);
            hpick   = $urandom_range(0, 99);
            vel     = ($urandom_range(0, 99) < 8) ? 7'd0 : 7'($urandom_range(1, 127));
            chan    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(1, 16));
            hold    = (hpick < 10) ? 32'd0 :
                      (hpick < 15) ? 32'($urandom) : 32'($urandom_range(1, 300));
            now     = ($urandom_range(0, 99) < 5) ? 32'($urandom) : wall_ms;
            push_req((pick < 55) ? tnva_pkg::OP_NOTE : tnva_pkg::OP_TICK,
                     7'($urandom_range(0, 127)),
                     vel, hold, chan, now, $urandom_range(0, 99) < 2);
        end
    endtask

    task automatic run_phase(input logic [3:0] voices, input logic per_note,
                             input logic [4:0] gchan, input logic [1:0] led,
                             input logic [7:0] bright, input int idle_pct,
                             input int count);
        write_reg(tnva_pkg::CFG_VOICES_IN_USE, tnva_pkg::CFG_DATA_W'(voices));
        write_reg(tnva_pkg::CFG_USE_NOTE_CHANNEL, tnva_pkg::CFG_DATA_W'(per_note));
        write_reg(tnva_pkg::CFG_GLOBAL_CHANNEL, tnva_pkg::CFG_DATA_W'(gchan));
        write_reg(tnva_pkg::CFG_LED_MODE, tnva_pkg::CFG_DATA_W'(led));
        write_reg(tnva_pkg::CFG_LED_MAX_BRIGHTNESS, bright);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        send_idle_pct = idle_pct;
        queue_random(count);
        wait_quiet();
    endtask

    initial begin
        start           = 1'b0;
        i_rst_n         = 1'b0;
        i_operation     = tnva_pkg::OP_NOTE;
        i_note_number   = '0;
        i_note_velocity = '0;
        i_hold_ms       = '0;
        i_note_channel  = '0;
        i_now_ms        = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        req_taken       = 1'b0;
        send_idle_pct   = 7;
        mismatch_cnt    = 0;
        stall_cycles    = 0;
        wall_ms         = 32'd1000;
        shadow_cfg.voices_in_use      = 4'd8;
        shadow_cfg.use_note_channel   = 1'b0;
        shadow_cfg.global_channel     = 5'd1;
        shadow_cfg.led_mode           = tnva_pkg::LED_NONE;
        shadow_cfg.led_max_brightness = 8'd255;
        for (int s = 0; s < VOICE_SLOTS; s++) begin
            voice_vel[s]    = 7'd0;
            voice_note[s]   = 7'd0;
            voice_expiry[s] = 32'd0;
            voice_chan[s]   = 5'd0;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, wrapped expiry, zero velocity,
        // odd channels, full table, mass release
        push_req(tnva_pkg::OP_NOTE, 7'd0,   7'd127, 32'd0,         5'd1,  32'd0, 1'b0);
        push_req(tnva_pkg::OP_NOTE, 7'd127, 7'd1,   32'hFFFF_FFFF, 5'd16, 32'd1, 1'b0);
        push_req(tnva_pkg::OP_NOTE, 7'd60,  7'd0,   32'd100,       5'd0,  32'd2, 1'b0);
        push_req(tnva_pkg::OP_NOTE, 7'd61,  7'd64,  32'd10,        5'd31, 32'd3, 1'b0);
        push_req(tnva_pkg::OP_TICK, 7'd0,   7'd0,   32'd0,         5'd0,  32'd0, 1'b0);
        for (int s = 0; s < 7; s++)
            push_req(tnva_pkg::OP_NOTE, 7'(10 + s), 7'(20 + s), 32'd1000, 5'(s + 1),
                     32'd20, 1'b0);
        push_req(tnva_pkg::OP_NOTE, 7'd99,  7'd99,  32'd5,         5'd5,  32'd21, 1'b0);
        push_req(tnva_pkg::OP_TICK, 7'd127, 7'd127, 32'hFFFF_FFFF, 5'd31, 32'd500, 1'b0);
        push_req(tnva_pkg::OP_TICK, 7'd0,   7'd0,   32'd0,         5'd0,  32'hFFFF_FFFF,
                 1'b1);
        push_req(tnva_pkg::OP_TICK, 7'd0,   7'd0,   32'd0,         5'd0,  32'd0, 1'b0);
        wait_quiet();

        // Random phases: sender idles 7%, then 74%, then not at all
        run_phase(4'd8,  1'b1, 5'd16, tnva_pkg::LED_SLOT,      8'd255, 7,  80);
        run_phase(4'd1,  1'b0, 5'd0,  tnva_pkg::LED_SLOT_PLUS, 8'd0,   7,  80);
        run_phase(4'd3,  1'b1, 5'd31, LED_MODE_SPARE,          8'd128, 74, 80);
        run_phase(4'd15, 1'b0, 5'd5,  tnva_pkg::LED_SLOT_PLUS, 8'd200, 74, 80);
        run_phase(4'd0,  1'b1, 5'd2,  tnva_pkg::LED_SLOT,      8'd1,   0,  16);
        wall_ms = 32'hFFFF_FF00;
        run_phase(4'd8,  1'b1, 5'd1,  tnva_pkg::LED_SLOT,      8'd77,  0,  80);
        run_phase(4'd5,  1'b0, 5'd9,  tnva_pkg::LED_NONE,      8'd255, 0,  80);

        if (mismatch_cnt == 0)
            $display("timed_note_voice_allocator_unit_tb: clean");
        else
            $display("timed_note_voice_allocator_unit_tb: errors");
        $finish;
    end

endmodule
